// ----- rtl/utf8d_pkg.sv -----
// Shared types and constants for the UTF-8 stream decoder.
// No dependencies; imported by every module under rtl/.
`timescale 1ns / 1ps
`default_nettype none

package utf8d_pkg;

    localparam int unsigned CP_W    = 21;
    localparam int unsigned CNT_W   = 3;
    localparam int unsigned TDATA_W = 24;
    localparam int unsigned TUSER_W = 2;

    localparam logic [CP_W-1:0] RPL_CP    = 21'h00FFFD;
    localparam logic [CP_W-1:0] CP_MAX    = 21'h10FFFF;
    localparam logic [CP_W-1:0] MIN_2BYTE = 21'h000080;
    localparam logic [CP_W-1:0] MIN_3BYTE = 21'h000800;
    localparam logic [CP_W-1:0] MIN_4BYTE = 21'h010000;

    // tuser bit positions on the result side
    localparam int unsigned TUSER_ERR = 0;
    localparam int unsigned TUSER_END = 1;

    // Pending sequence state
    typedef struct packed {
        logic [7:0]      lead_byte;
        logic [1:0]      bytes_needed;
        logic [1:0]      bytes_held;
        logic [CP_W-1:0] partial_value;
    } t_dec_state;

    // Results caused by one byte: err_cnt replacements, then an optional tail
    typedef struct packed {
        logic [CNT_W-1:0] err_cnt;
        logic             has_tail;
        logic             tail_end;
        logic [CP_W-1:0]  tail_cp;
    } t_burst;

endpackage

`default_nettype wire

// ----- rtl/utf8d_decode.sv -----
// Byte decoder: sequence state register plus the per-byte decode logic.
// Depends on utf8d_pkg.
`timescale 1ns / 1ps
`default_nettype none

module utf8d_decode
    import utf8d_pkg::*;
(
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_commit,
    input  wire logic [7:0] i_byte,
    output t_burst          o_burst,
    output t_dec_state      o_state
);

    t_dec_state r_state;
    t_dec_state n_state;

    logic            w_pending;
    logic            w_cont;
    logic [CP_W-1:0] w_pv;
    logic [1:0]      w_needed_dec;
    logic [2:0]      w_held_inc;
    logic            w_bad;
    logic            w_fresh;
    logic [CNT_W-1:0] w_flush;

    always_comb begin
        w_pending    = (r_state.bytes_needed != 2'd0);
        w_cont       = (i_byte[7:6] == 2'b10);
        w_pv         = {r_state.partial_value[CP_W-7:0], i_byte[5:0]};
        w_needed_dec = r_state.bytes_needed - 2'd1;
        w_held_inc   = {1'b0, r_state.bytes_held} + 3'd1;

        // overlong / out-of-range check on a completed sequence
        if (r_state.lead_byte[7:5] == 3'b110) begin
            w_bad = (w_pv < MIN_2BYTE);
        end else if (r_state.lead_byte[7:4] == 4'b1110) begin
            w_bad = (w_pv < MIN_3BYTE);
        end else begin
            w_bad = (w_pv < MIN_4BYTE) || (w_pv > CP_MAX);
        end

        n_state          = r_state;
        o_burst.err_cnt  = '0;
        o_burst.has_tail = 1'b0;
        o_burst.tail_end = 1'b0;
        o_burst.tail_cp  = '0;
        w_fresh          = 1'b1;
        w_flush          = '0;

        if (w_pending) begin
            if (w_cont) begin
                w_fresh = 1'b0;
                if (w_needed_dec != 2'd0) begin
                    n_state.bytes_needed  = w_needed_dec;
                    n_state.bytes_held    = w_held_inc[1:0];
                    n_state.partial_value = w_pv;
                end else begin
                    n_state = '0;
                    if (w_bad) begin
                        o_burst.err_cnt = w_held_inc;
                    end else begin
                        o_burst.has_tail = 1'b1;
                        o_burst.tail_cp  = w_pv;
                    end
                end
            end else begin
                // broken sequence: flush held bytes, then decode afresh
                w_flush = {1'b0, r_state.bytes_held};
                n_state = '0;
            end
        end

        if (w_fresh) begin
            o_burst.err_cnt = w_flush;
            priority if (i_byte == 8'h00) begin
                o_burst.has_tail = 1'b1;
                o_burst.tail_end = 1'b1;
            end else if (i_byte[7] == 1'b0) begin
                o_burst.has_tail = 1'b1;
                o_burst.tail_cp  = {{(CP_W-8){1'b0}}, i_byte};
            end else if (i_byte[7:5] == 3'b110) begin
                n_state.lead_byte     = i_byte;
                n_state.bytes_needed  = 2'd1;
                n_state.bytes_held    = 2'd1;
                n_state.partial_value = {{(CP_W-5){1'b0}}, i_byte[4:0]};
            end else if (i_byte[7:4] == 4'b1110) begin
                n_state.lead_byte     = i_byte;
                n_state.bytes_needed  = 2'd2;
                n_state.bytes_held    = 2'd1;
                n_state.partial_value = {{(CP_W-4){1'b0}}, i_byte[3:0]};
            end else if (i_byte[7:3] == 5'b11110) begin
                n_state.lead_byte     = i_byte;
                n_state.bytes_needed  = 2'd3;
                n_state.bytes_held    = 2'd1;
                n_state.partial_value = {{(CP_W-3){1'b0}}, i_byte[2:0]};
            end else begin
                // stray continuation or F8-FF
                o_burst.err_cnt = w_flush + 3'd1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= '0;
        end else if (i_commit) begin
            r_state <= n_state;
        end
    end

    assign o_state = r_state;

endmodule

`default_nettype wire

// ----- rtl/utf8d_emit.sv -----
// Result register: holds one byte's results and hands them out one per beat.
// Depends on utf8d_pkg.
`timescale 1ns / 1ps
`default_nettype none

module utf8d_emit
    import utf8d_pkg::*;
(
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_load,
    input  wire t_burst             i_burst,
    output logic                    o_free,
    output logic                    o_tvalid,
    input  wire logic               i_tready,
    output logic [TDATA_W-1:0]      o_tdata,
    output logic [TUSER_W-1:0]      o_tuser,
    output logic                    o_tlast
);

    logic [CNT_W-1:0] r_left;
    logic [CNT_W-1:0] n_left;
    logic             r_has_tail;
    logic             r_tail_end;
    logic [CP_W-1:0]  r_tail_cp;
    logic             w_on_tail;
    logic             w_last_beat;

    assign w_last_beat = (r_left == CNT_W'(1));
    assign w_on_tail   = r_has_tail && w_last_beat;
    assign o_tvalid    = (r_left != '0);
    assign o_free      = (r_left == '0) || (w_last_beat && i_tready);
    assign o_tlast     = w_last_beat;
    assign o_tdata     = {{(TDATA_W-CP_W){1'b0}}, (w_on_tail ? r_tail_cp : RPL_CP)};
    assign o_tuser[TUSER_ERR] = !w_on_tail;
    assign o_tuser[TUSER_END] = w_on_tail && r_tail_end;

    always_comb begin
        n_left = r_left;
        if (o_tvalid && i_tready) begin
            n_left = r_left - CNT_W'(1);
        end
        if (i_load) begin
            n_left = i_burst.err_cnt + CNT_W'(i_burst.has_tail);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_left <= '0;
        end else begin
            r_left <= n_left;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_has_tail <= i_burst.has_tail;
            r_tail_end <= i_burst.tail_end;
            r_tail_cp  <= i_burst.tail_cp;
        end
    end

endmodule

`default_nettype wire

// ----- rtl/utf8_stream_decoder_unit.sv -----
// Top level of the UTF-8 stream decoder: input register, decoder, result register.
// Depends on utf8d_pkg, utf8d_decode and utf8d_emit.
`timescale 1ns / 1ps
`default_nettype none

// Usage
//  - Slave stream: one raw UTF-8 byte per transaction; a zero byte ends the string.
//  - Master stream: one decoded code point per transaction. tuser bit 0 marks a
//    replacement (U+FFFD) for a malformed byte, bit 1 the end-of-string result.
//    tlast marks the final result caused by one input byte.
//  - A byte is held in an input register, decoded by one level of logic and its
//    results (up to four) parked in the result register. The first result is
//    shown once the byte has passed the input register into the result register.
//  - Throughput: one byte per cycle while each byte gives at most one result
//    and the receiver does not stall. A byte giving N results occupies the
//    result register for N beats; the input register keeps taking one more
//    byte meanwhile, then s_axis_tready drops until the burst drains.
//  - Bytes inside a multi-byte sequence give no result and pass at full rate.
//  - Reset (synchronous, active low) empties both registers and drops any
//    pending partial sequence.
//  - When the receiver stalls, the current result holds steady; the block
//    keeps one byte in hand and then back-pressures the source.

module utf8_stream_decoder_unit
    import utf8d_pkg::*;
(
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    // tdata: [7:0] byte_in
    input  wire logic [7:0]         s_axis_tdata,
    input  wire logic               s_axis_tvalid,
    output logic                    s_axis_tready,
    // tdata: [20:0] code_point, [23:21] zero
    output logic [TDATA_W-1:0]      m_axis_tdata,
    // tuser: [0] is_error, [1] string_end
    output logic [TUSER_W-1:0]      m_axis_tuser,
    output logic                    m_axis_tlast,
    output logic                    m_axis_tvalid,
    input  wire logic               m_axis_tready
);

    logic       r_in_valid;
    logic [7:0] r_in_byte;
    logic       w_move;
    logic       w_load;
    logic       w_emit_free;
    logic       w_no_result;
    t_burst     w_burst;
    t_dec_state w_state;

    // decoder for the held byte
    utf8d_decode u_decode (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_commit (w_move),
        .i_byte   (r_in_byte),
        .o_burst  (w_burst),
        .o_state  (w_state)
    );

    // a byte may leave the input register when its results fit or it has none
    assign w_no_result   = (w_burst.err_cnt == '0) && !w_burst.has_tail;
    assign w_move        = r_in_valid && (w_no_result || w_emit_free);
    assign w_load        = w_move && !w_no_result;
    assign s_axis_tready = !r_in_valid || w_move;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (s_axis_tready) begin
            r_in_valid <= s_axis_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_axis_tready && s_axis_tvalid) begin
            r_in_byte <= s_axis_tdata;
        end
    end

    // result register and serialiser
    utf8d_emit u_emit (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_load   (w_load),
        .i_burst  (w_burst),
        .o_free   (w_emit_free),
        .o_tvalid (m_axis_tvalid),
        .i_tready (m_axis_tready),
        .o_tdata  (m_axis_tdata),
        .o_tuser  (m_axis_tuser),
        .o_tlast  (m_axis_tlast)
    );

    // end-of-string result is always the final, error-free one of its byte
    a_end_is_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tuser[TUSER_END] |-> m_axis_tlast && !m_axis_tuser[TUSER_ERR])
        else $error("string end result not last or flagged as error");

    // a decoded (non-replacement) code point is never above the Unicode range
    a_cp_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tuser[TUSER_ERR] |-> m_axis_tdata[CP_W-1:0] <= CP_MAX)
        else $error("decoded code point out of range");

    // pending sequence: held plus still needed always covers a 2..4 byte sequence
    a_seq_len: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_state.bytes_needed != 2'd0 |->
            ({1'b0, w_state.bytes_needed} + {1'b0, w_state.bytes_held} >= 3'd2) &&
            (w_state.bytes_held != 2'd0))
        else $error("inconsistent pending sequence state");

    // a byte that yields results never leaves while the result register is busy
    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_load |-> w_emit_free)
        else $error("result register overwritten");

endmodule

`default_nettype wire

// ----- bench/utf8_stream_checker.sv -----
// Scoreboard for the UTF-8 stream decoder: watches both stream channels, predicts
// the code points for every accepted byte and compares each accepted result.
// Depends on utf8d_pkg for widths, tuser bit positions and the code point limits.
`timescale 1ns / 1ps

module utf8_stream_checker
    import utf8d_pkg::*;
(
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    // byte side: tdata [7:0] byte_in
    input  wire logic [7:0]         i_in_tdata,
    input  wire logic               i_in_tvalid,
    input  wire logic               i_in_tready,
    // result side: tdata [20:0] code_point, [23:21] zero; tuser [0] is_error, [1] string_end
    input  wire logic [TDATA_W-1:0] i_out_tdata,
    input  wire logic [TUSER_W-1:0] i_out_tuser,
    input  wire logic               i_out_tlast,
    input  wire logic               i_out_tvalid,
    input  wire logic               i_out_tready,
    output int                      o_pending,
    output int                      o_fail_count
);

    localparam int unsigned MAX_BEATS = 4;

    typedef struct packed {
        logic [CP_W-1:0] code_point;
        logic            is_error;
        logic            string_end;
        logic            last;
    } t_cp_beat;

    // Decoder state as the predictor sees it
    logic [7:0]      seq_lead;
    logic [1:0]      seq_need;
    logic [1:0]      seq_held;
    logic [CP_W-1:0] seq_acc;

    t_cp_beat step_q[$];          // results of the byte being predicted
    t_cp_beat cp_expected_q[$];   // code points still owed by the block
    int       fail_count = 0;
    int       beat_idx   = 0;

    assign o_fail_count = fail_count;

    task automatic report_mismatch(input string what, input int unsigned got,
                                   input int unsigned want);
        $display("%0t ns: result %0d, %s: got %h, expected %h",
                 $time, beat_idx, what, got, want);
        fail_count++;
    endtask

    function automatic void clear_seq();
        seq_lead = 8'd0;
        seq_need = 2'd0;
        seq_held = 2'd0;
        seq_acc  = '0;
    endfunction

    function automatic void open_seq(input logic [7:0] lead, input logic [1:0] need,
                                     input logic [4:0] bits);
        seq_lead = lead;
        seq_need = need;
        seq_held = 2'd1;
        seq_acc  = {{(CP_W-5){1'b0}}, bits};
    endfunction

    function automatic void add_beat(input logic [CP_W-1:0] cp, input logic err,
                                     input logic at_end);
        t_cp_beat beat;
        beat.code_point = cp;
        beat.is_error   = err;
        beat.string_end = at_end;
        beat.last       = 1'b0;
        step_q.push_back(beat);
    endfunction

    function automatic void add_replacements(input int unsigned cnt);
        for (int i = 0; i < cnt && step_q.size() < MAX_BEATS; i++)
            add_beat(RPL_CP, 1'b1, 1'b0);
    endfunction

    // Works out the code points one input byte gives and queues them.
    function automatic void predict_code_points(input logic [7:0] b);
        logic [2:0]      held;
        logic [CP_W-1:0] cp;
        logic            bad;
        t_cp_beat        tail;
        step_q.delete();
        if (seq_need != 2'd0 && b[7:6] == 2'b10) begin
            held     = {1'b0, seq_held} + 3'd1;
            seq_acc  = {seq_acc[CP_W-7:0], b[5:0]};
            seq_need = seq_need - 2'd1;
            if (seq_need != 2'd0) begin
                seq_held = held[1:0];
            end else begin
                cp = seq_acc;
                // overlong forms and values past the Unicode range are rejected
                if (seq_lead[7:5] == 3'b110)
                    bad = cp < MIN_2BYTE;
                else if (seq_lead[7:4] == 4'b1110)
                    bad = cp < MIN_3BYTE;
                else
                    bad = cp < MIN_4BYTE || cp > CP_MAX;
                if (bad)
                    add_replacements(32'(held));
                else
                    add_beat(cp, 1'b0, 1'b0);
                clear_seq();
            end
        end else begin
            // a broken sequence is flushed, then the byte is decoded afresh
            if (seq_need != 2'd0) begin
                add_replacements(32'(seq_held));
                clear_seq();
            end
            if (b == 8'h00)
                add_beat('0, 1'b0, 1'b1);
            else if (!b[7])
                add_beat({{(CP_W-8){1'b0}}, b}, 1'b0, 1'b0);
            else if (b[7:5] == 3'b110)
                open_seq(b, 2'd1, b[4:0]);
            else if (b[7:4] == 4'b1110)
                open_seq(b, 2'd2, {1'b0, b[3:0]});
            else if (b[7:3] == 5'b11110)
                open_seq(b, 2'd3, {2'b00, b[2:0]});
            else
                add_beat(RPL_CP, 1'b1, 1'b0);
        end
        if (step_q.size() != 0) begin
            tail      = step_q.pop_back();
            tail.last = 1'b1;
            step_q.push_back(tail);
        end
        foreach (step_q[i])
            cp_expected_q.push_back(step_q[i]);
    endfunction

    always @(posedge i_clk) begin
        t_cp_beat want;
        if (!i_rst_n) begin
            clear_seq();
            cp_expected_q.delete();
            o_pending <= 0;
        end else begin
            // results first: a byte accepted on this edge cannot have one out yet
            if (i_out_tvalid && i_out_tready) begin
                if (cp_expected_q.size() == 0) begin
                    report_mismatch("result with nothing expected", 32'(i_out_tdata), 0);
                end else begin
                    want = cp_expected_q.pop_front();
                    if (i_out_tdata != {{(TDATA_W-CP_W){1'b0}}, want.code_point})
                        report_mismatch("code_point", 32'(i_out_tdata),
                                        32'(want.code_point));
                    if (i_out_tuser[TUSER_ERR] != want.is_error)
                        report_mismatch("is_error", 32'(i_out_tuser[TUSER_ERR]),
                                        32'(want.is_error));
                    if (i_out_tuser[TUSER_END] != want.string_end)
                        report_mismatch("string_end", 32'(i_out_tuser[TUSER_END]),
                                        32'(want.string_end));
                    if (i_out_tlast != want.last)
                        report_mismatch("last", 32'(i_out_tlast), 32'(want.last));
                end
                beat_idx++;
            end
            if (i_in_tvalid && i_in_tready)
                predict_code_points(i_in_tdata);
            o_pending <= cp_expected_q.size();
        end
    end

endmodule

// ----- bench/tb_utf8_stream_decoder_unit.sv -----
// Testbench top for utf8_stream_decoder_unit: clock, reset, byte stimulus and verdict.
// Depends on utf8d_pkg, the decoder RTL and utf8_stream_checker.
`timescale 1ns / 1ps

module tb_utf8_stream_decoder_unit
    import utf8d_pkg::*;
();

    // Longest quiet stretch in a correct run is the receiver hold-off below; the
    // watchdog allows ten times that before calling the run hung.
    localparam int unsigned HOLD_CYCLES = 200;
    localparam int unsigned DOG_LIMIT   = 2000;
    localparam int unsigned DRAIN_TAIL  = 10;   // margin after the checker drains
    localparam int unsigned PHASE_BYTES = 18;

    logic               i_clk         = 1'b0;
    logic               i_rst_n       = 1'b0;
    logic [7:0]         s_axis_tdata  = 8'd0;   // [7:0] byte_in
    logic               s_axis_tvalid = 1'b0;
    logic               s_axis_tready;
    logic [TDATA_W-1:0] m_axis_tdata;           // [20:0] code_point, [23:21] zero
    logic [TUSER_W-1:0] m_axis_tuser;           // [0] is_error, [1] string_end
    logic               m_axis_tlast;
    logic               m_axis_tvalid;
    logic               m_axis_tready = 1'b0;

    int          pending;
    int          fail_count;
    int unsigned bytes_sent     = 0;
    int unsigned send_idle_pct  = 0;   // used by the stimulus process only
    int unsigned recv_stall_pct = 0;   // written with NBAs, read by the receiver
    int unsigned hold_token     = 0;   // bumped to ask the receiver for a hold-off
    int unsigned hold_seen      = 0;
    int unsigned hold_left      = 0;
    int unsigned quiet_cycles   = 0;

    // Bytes exercising the ends of the ranges and every error path:
    //   smallest and largest ASCII, smallest 2-byte value, largest scalar,
    //   a surrogate (accepted), an overlong 4-byte form (four replacements),
    //   a value past U+10FFFF, a sequence broken by ASCII, a sequence cut by
    //   the terminating zero, a stray continuation and an invalid lead.
    logic [7:0] directed_bytes [27] = '{
        8'h01, 8'h7F,
        8'hC2, 8'h80,
        8'hF4, 8'h8F, 8'hBF, 8'hBF,
        8'hED, 8'hA0, 8'h80,
        8'hF0, 8'h80, 8'h80, 8'h80,
        8'hF4, 8'h90, 8'h80, 8'h80,
        8'hE2, 8'h82, 8'h41,
        8'hF0, 8'h90, 8'h00,
        8'hBF,
        8'hFF
    };

    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    utf8_stream_decoder_unit i_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready)
    );

    utf8_stream_checker i_checker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_tdata   (s_axis_tdata),
        .i_in_tvalid  (s_axis_tvalid),
        .i_in_tready  (s_axis_tready),
        .i_out_tdata  (m_axis_tdata),
        .i_out_tuser  (m_axis_tuser),
        .i_out_tlast  (m_axis_tlast),
        .i_out_tvalid (m_axis_tvalid),
        .i_out_tready (m_axis_tready),
        .o_pending    (pending),
        .o_fail_count (fail_count)
    );

    // Receiver: random stalls, or a long hold-off when the token moves. The
    // hold-off lets the decoder fill both registers and push back on the source.
    always @(posedge i_clk) begin
        if (hold_token != hold_seen) begin
            hold_seen     <= hold_token;
            hold_left     <= HOLD_CYCLES;
            m_axis_tready <= 1'b0;
        end else if (hold_left != 0) begin
            hold_left     <= hold_left - 1;
            m_axis_tready <= 1'b0;
        end else begin
            m_axis_tready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    // Watchdog: ends the run after too long without any transaction on either side.
    always @(posedge i_clk) begin
        if (!i_rst_n || (s_axis_tvalid && s_axis_tready) ||
            (m_axis_tvalid && m_axis_tready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= DOG_LIMIT) begin
            $display("watchdog: no transaction for %0d cycles", DOG_LIMIT);
            $display("** utf8_stream_decoder_unit: FAILED **");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    // One byte transaction; tvalid stays up between back-to-back bytes.
    task automatic send_byte(input logic [7:0] b);
        while ($urandom_range(99) < send_idle_pct) begin
            s_axis_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= b;
        @(posedge i_clk);
        while (!s_axis_tready)
            @(posedge i_clk);
        bytes_sent++;
    endtask

    // Sends the first nbytes of the len-byte encoding of cp, overlong or not.
    task automatic send_encoded(input logic [20:0] cp, input int unsigned len,
                                input int unsigned nbytes);
        logic [7:0] enc [4];
        case (len)
            1: begin
                enc[0] = {1'b0, cp[6:0]};
            end
            2: begin
                enc[0] = {3'b110, cp[10:6]};
                enc[1] = {2'b10, cp[5:0]};
            end
            3: begin
                enc[0] = {4'b1110, cp[15:12]};
                enc[1] = {2'b10, cp[11:6]};
                enc[2] = {2'b10, cp[5:0]};
            end
            default: begin
                enc[0] = {5'b11110, cp[20:18]};
                enc[1] = {2'b10, cp[17:12]};
                enc[2] = {2'b10, cp[11:6]};
                enc[3] = {2'b10, cp[5:0]};
            end
        endcase
        for (int i = 0; i < nbytes; i++)
            send_byte(enc[i]);
    endtask

    // Mostly well-formed text with random content; the rest malformed or noise.
    task automatic send_random_sequence();
        int unsigned pick;
        int unsigned len;
        int unsigned floor_cp;
        logic [7:0]  brk;
        pick = $urandom_range(99);
        len  = $urandom_range(4, 2);
        floor_cp = (len == 2) ? 32'h80 : (len == 3) ? 32'h800 : 32'h10000;
        if (pick < 30) begin
            send_byte(8'($urandom_range(8'h7F, 8'h01)));
        end else if (pick < 45) begin
            send_encoded(21'($urandom_range(21'h7FF, 21'h80)), 2, 2);
        end else if (pick < 58) begin
            send_encoded(21'($urandom_range(21'hFFFF, 21'h800)), 3, 3);
        end else if (pick < 68) begin
            send_encoded(21'($urandom_range(21'h10FFFF, 21'h10000)), 4, 4);
        end else if (pick < 73) begin
            // overlong: value fits a shorter form
            send_encoded(21'($urandom_range(floor_cp - 1, 0)), len, len);
        end else if (pick < 77) begin
            send_encoded(21'($urandom_range(21'h1FFFFF, 21'h110000)), 4, 4);
        end else if (pick < 83) begin
            // cut short by any byte that is not a continuation
            send_encoded(21'($urandom), len, $urandom_range(len - 1, 1));
            do
                brk = 8'($urandom);
            while (brk[7:6] == 2'b10);
            send_byte(brk);
        end else if (pick < 87) begin
            send_byte(8'h00);
        end else if (pick < 91) begin
            send_byte(8'($urandom_range(8'hBF, 8'h80)));
        end else if (pick < 94) begin
            send_byte(8'($urandom_range(8'hFF, 8'hF8)));
        end else begin
            send_byte(8'($urandom_range(8'hFF, 8'h00)));
        end
    endtask

    initial begin
        int unsigned target;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;

        foreach (directed_bytes[i])
            send_byte(directed_bytes[i]);

        // random text under each idling pattern
        for (int phase = 0; phase < 4; phase++) begin
            case (phase)
                0: begin send_idle_pct = 0;  recv_stall_pct <= 0;  end
                1: begin send_idle_pct = 57; recv_stall_pct <= 0;  end
                2: begin send_idle_pct = 0;  recv_stall_pct <= 57; end
                default: begin send_idle_pct = 6; recv_stall_pct <= 6; end
            endcase
            target = bytes_sent + PHASE_BYTES;
            while (bytes_sent < target)
                send_random_sequence();
        end

        // back-pressure: receiver holds off while bytes keep coming at full rate
        send_idle_pct = 0;
        recv_stall_pct <= 0;
        hold_token <= hold_token + 1;
        target = bytes_sent + PHASE_BYTES;
        while (bytes_sent < target)
            send_random_sequence();
        s_axis_tvalid <= 1'b0;

        // the checker's count is registered, so it lags behind the last transaction
        @(posedge i_clk);
        while (pending != 0)
            @(posedge i_clk);
        repeat (DRAIN_TAIL) @(posedge i_clk);

        if (fail_count == 0)
            $display("** utf8_stream_decoder_unit: PASSED **");
        else
            $display("** utf8_stream_decoder_unit: FAILED **");
        $finish;
    end

endmodule

// ----- sim.f -----
rtl/utf8d_pkg.sv
rtl/utf8d_decode.sv
rtl/utf8d_emit.sv
rtl/utf8_stream_decoder_unit.sv
bench/utf8_stream_checker.sv
bench/tb_utf8_stream_decoder_unit.sv
